[rtl/swkv_pkg.sv]
// shared constants, types and codes for the sliding window key/value store
package swkv_pkg;

    // store geometry
    localparam int WINDOW_DEPTH = 8;
    localparam int DIM_MAX      = 8;
    localparam int DATA_WIDTH   = 32;

    localparam int STORE_DEPTH = WINDOW_DEPTH * DIM_MAX;
    localparam int SLOT_W      = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int DIM_W       = (DIM_MAX > 1) ? $clog2(DIM_MAX) : 1;
    localparam int FILL_W      = $clog2(WINDOW_DEPTH + 1);
    localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

    // configuration port
    localparam int CFG_W     = 4;
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_WIN_LEN = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_VEC_LEN = 1'b1;
    localparam logic [CFG_W-1:0]     WIN_LEN_RST = 4'd8;
    localparam logic [CFG_W-1:0]     VEC_LEN_RST = 4'd8;

    // word fields
    localparam int WORD_W    = 32;
    localparam int IDX_W     = 3;
    localparam int FILLED_W  = 4;
    localparam int S_TDATA_W = 2 * WORD_W;
    localparam int M_FIELD_W = 2 * WORD_W + 2 * IDX_W + FILLED_W;
    localparam int M_TDATA_W = ((M_FIELD_W + 7) / 8) * 8;
    localparam int M_PAD_W   = M_TDATA_W - M_FIELD_W;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_EMIT
    } ctrl_state_t;

    // controller to datapath
    typedef struct packed {
        logic append;   // store the incoming word
        logic clear;    // empty the ring
        logic issue;    // read the current window element
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic pipe_busy;     // read stage still holds a word
        logic pipe_free;     // read stage can take a new read this cycle
        logic window_empty;  // nothing to emit
        logic issue_last;    // current element is the final one of the window
    } status_t;

endpackage

[rtl/swkv_ram.sv]
// generic simple dual port ram with registered read
module swkv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                       aclk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic                                       re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/swkv_ctrl.sv]
// control state machine: input acceptance and window read sequencing
module swkv_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic              s_tlast,
    input  logic              s_tuser,
    input  swkv_pkg::status_t status,
    output swkv_pkg::cmd_t    cmd
);

    import swkv_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = !status.pipe_busy;
                if (s_tvalid && !status.pipe_busy) begin
                    if (s_tuser) begin
                        cmd.clear = 1'b1;
                    end else begin
                        cmd.append = 1'b1;
                        if (s_tlast) begin
                            state_next = ST_EMIT;
                        end
                    end
                end
            end
            ST_EMIT: begin
                if (status.window_empty) begin
                    state_next = ST_IDLE;
                end else if (status.pipe_free) begin
                    cmd.issue = 1'b1;
                    if (status.issue_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef ASSERT_OFF
    a_emit_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT && cmd.issue && status.issue_last) |=> state_reg == ST_IDLE)
        else $error("window read did not end after its final element");

    a_no_accept_in_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT) |-> !(cmd.append || cmd.clear))
        else $error("word taken while the window is being read");
`endif

endmodule

[rtl/swkv_dp.sv]
// datapath: ring pointers, key/value memories, read stage and output register
module swkv_dp (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [swkv_pkg::CFG_IDX_W-1:0]      cfg_addr,
    input  logic [swkv_pkg::CFG_W-1:0]          cfg_wdata,
    input  swkv_pkg::cmd_t                      cmd,
    output swkv_pkg::status_t                   status,
    input  logic [swkv_pkg::WORD_W-1:0]         key_in,
    input  logic [swkv_pkg::WORD_W-1:0]         value_in,
    input  logic                                end_in,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [swkv_pkg::WORD_W-1:0]         key_out,
    output logic [swkv_pkg::WORD_W-1:0]         value_out,
    output logic [swkv_pkg::IDX_W-1:0]          dim_index,
    output logic [swkv_pkg::IDX_W-1:0]          position_index,
    output logic [swkv_pkg::FILLED_W-1:0]       filled_positions,
    output logic                                last
);

    import swkv_pkg::*;

    localparam int SUM_W = CFG_W + 1;

    function automatic logic [CFG_W-1:0] clamp_cfg(input logic [CFG_W-1:0] v,
                                                   input logic [CFG_W-1:0] hi);
        logic [CFG_W-1:0] r;
        r = v;
        if (v == '0) begin
            r = CFG_W'(1);
        end else if (v > hi) begin
            r = hi;
        end
        return r;
    endfunction

    // configuration
    logic [CFG_W-1:0] win_len_reg, win_len_next;
    logic [CFG_W-1:0] vec_len_reg, vec_len_next;

    // ring state
    logic [SLOT_W-1:0] write_slot_reg, write_slot_next;
    logic [FILL_W-1:0] fill_count_reg, fill_count_next;
    logic [DIM_W-1:0]  dim_counter_reg, dim_counter_next;

    // window read counters
    logic [DIM_W-1:0]  emit_d_reg, emit_d_next;
    logic [SLOT_W-1:0] emit_t_reg, emit_t_next;

    // read stage
    logic              rd_valid_reg, rd_valid_next;
    logic [DIM_W-1:0]  rd_dim_reg, rd_dim_next;
    logic [SLOT_W-1:0] rd_pos_reg, rd_pos_next;
    logic              rd_last_reg, rd_last_next;

    // output register
    logic                m_valid_reg, m_valid_next;
    logic [WORD_W-1:0]   key_out_reg, key_out_next;
    logic [WORD_W-1:0]   value_out_reg, value_out_next;
    logic [IDX_W-1:0]    dim_out_reg, dim_out_next;
    logic [IDX_W-1:0]    pos_out_reg, pos_out_next;
    logic [FILLED_W-1:0] filled_out_reg, filled_out_next;
    logic                last_out_reg, last_out_next;

    logic [CFG_W-1:0]      hd;
    logic [CFG_W-1:0]      ws;
    logic [CFG_W-1:0]      fill_ext;
    logic [CFG_W-1:0]      win_n;
    logic [SUM_W-1:0]      slot_sum;
    logic [SLOT_W-1:0]     rd_slot;
    logic [ADDR_W-1:0]     rd_addr;
    logic [ADDR_W-1:0]     wr_addr;
    logic                  t_last;
    logic                  d_last;
    logic                  out_free;
    logic [DATA_WIDTH-1:0] key_rdata;
    logic [DATA_WIDTH-1:0] value_rdata;

    assign hd       = clamp_cfg(vec_len_reg, CFG_W'(DIM_MAX));
    assign ws       = clamp_cfg(win_len_reg, CFG_W'(WINDOW_DEPTH));
    assign fill_ext = CFG_W'(fill_count_reg);
    assign win_n    = (fill_ext < ws) ? fill_ext : ws;

    // oldest emitted slot plus position, taken modulo the ring depth
    assign slot_sum = SUM_W'(write_slot_reg) + SUM_W'(WINDOW_DEPTH) - SUM_W'(win_n)
                    + SUM_W'(emit_t_reg);
    assign rd_slot  = (slot_sum >= SUM_W'(WINDOW_DEPTH))
                    ? SLOT_W'(slot_sum - SUM_W'(WINDOW_DEPTH)) : SLOT_W'(slot_sum);
    assign rd_addr  = ADDR_W'(ADDR_W'(rd_slot) * ADDR_W'(DIM_MAX) + ADDR_W'(emit_d_reg));
    assign wr_addr  = ADDR_W'(ADDR_W'(write_slot_reg) * ADDR_W'(DIM_MAX)
                    + ADDR_W'(dim_counter_reg));

    assign t_last   = (CFG_W'(emit_t_reg) == win_n - CFG_W'(1));
    assign d_last   = (CFG_W'(emit_d_reg) == hd - CFG_W'(1));
    assign out_free = !m_valid_reg || m_tready;

    assign status.pipe_busy    = rd_valid_reg;
    assign status.pipe_free    = !rd_valid_reg || out_free;
    assign status.window_empty = (win_n == '0);
    assign status.issue_last   = t_last && d_last;

    swkv_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (STORE_DEPTH)
    ) u_key_ram (
        .aclk  (aclk),
        .we    (cmd.append),
        .waddr (wr_addr),
        .wdata (DATA_WIDTH'(key_in)),
        .re    (cmd.issue),
        .raddr (rd_addr),
        .rdata (key_rdata)
    );

    swkv_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (STORE_DEPTH)
    ) u_value_ram (
        .aclk  (aclk),
        .we    (cmd.append),
        .waddr (wr_addr),
        .wdata (DATA_WIDTH'(value_in)),
        .re    (cmd.issue),
        .raddr (rd_addr),
        .rdata (value_rdata)
    );

    // configuration and ring pointers
    always_comb begin
        win_len_next     = win_len_reg;
        vec_len_next     = vec_len_reg;
        write_slot_next  = write_slot_reg;
        fill_count_next  = fill_count_reg;
        dim_counter_next = dim_counter_reg;
        emit_d_next      = emit_d_reg;
        emit_t_next      = emit_t_reg;

        if (cfg_we) begin
            case (cfg_addr)
                CFG_WIN_LEN: win_len_next = cfg_wdata;
                CFG_VEC_LEN: vec_len_next = cfg_wdata;
                default:     ;
            endcase
        end

        if (cmd.clear) begin
            write_slot_next  = '0;
            fill_count_next  = '0;
            dim_counter_next = '0;
        end else if (cmd.append) begin
            if ((CFG_W'(dim_counter_reg) + CFG_W'(1)) >= hd) begin
                dim_counter_next = '0;
                write_slot_next  = (write_slot_reg == SLOT_W'(WINDOW_DEPTH - 1))
                                 ? '0 : write_slot_reg + SLOT_W'(1);
                if (fill_count_reg < FILL_W'(WINDOW_DEPTH)) begin
                    fill_count_next = fill_count_reg + FILL_W'(1);
                end
            end else begin
                dim_counter_next = dim_counter_reg + DIM_W'(1);
            end
            // partial position at the end mark is dropped
            if (end_in) begin
                dim_counter_next = '0;
            end
            emit_d_next = '0;
            emit_t_next = '0;
        end

        if (cmd.issue) begin
            if (t_last) begin
                emit_t_next = '0;
                emit_d_next = emit_d_reg + DIM_W'(1);
            end else begin
                emit_t_next = emit_t_reg + SLOT_W'(1);
            end
        end
    end

    // read stage and output register
    always_comb begin
        rd_valid_next   = rd_valid_reg;
        rd_dim_next     = rd_dim_reg;
        rd_pos_next     = rd_pos_reg;
        rd_last_next    = rd_last_reg;
        m_valid_next    = m_valid_reg;
        key_out_next    = key_out_reg;
        value_out_next  = value_out_reg;
        dim_out_next    = dim_out_reg;
        pos_out_next    = pos_out_reg;
        filled_out_next = filled_out_reg;
        last_out_next   = last_out_reg;

        if (m_tready) begin
            m_valid_next = 1'b0;
        end
        if (rd_valid_reg && out_free) begin
            m_valid_next    = 1'b1;
            key_out_next    = WORD_W'(key_rdata);
            value_out_next  = WORD_W'(value_rdata);
            dim_out_next    = IDX_W'(rd_dim_reg);
            pos_out_next    = IDX_W'(rd_pos_reg);
            filled_out_next = FILLED_W'(fill_count_reg);
            last_out_next   = rd_last_reg;
            rd_valid_next   = 1'b0;
        end
        if (cmd.issue) begin
            rd_valid_next = 1'b1;
            rd_dim_next   = emit_d_reg;
            rd_pos_next   = emit_t_reg;
            rd_last_next  = t_last && d_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_len_reg     <= WIN_LEN_RST;
            vec_len_reg     <= VEC_LEN_RST;
            write_slot_reg  <= '0;
            fill_count_reg  <= '0;
            dim_counter_reg <= '0;
            emit_d_reg      <= '0;
            emit_t_reg      <= '0;
            rd_valid_reg    <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            win_len_reg     <= win_len_next;
            vec_len_reg     <= vec_len_next;
            write_slot_reg  <= write_slot_next;
            fill_count_reg  <= fill_count_next;
            dim_counter_reg <= dim_counter_next;
            emit_d_reg      <= emit_d_next;
            emit_t_reg      <= emit_t_next;
            rd_valid_reg    <= rd_valid_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rd_dim_reg     <= rd_dim_next;
        rd_pos_reg     <= rd_pos_next;
        rd_last_reg    <= rd_last_next;
        key_out_reg    <= key_out_next;
        value_out_reg  <= value_out_next;
        dim_out_reg    <= dim_out_next;
        pos_out_reg    <= pos_out_next;
        filled_out_reg <= filled_out_next;
        last_out_reg   <= last_out_next;
    end

    assign m_tvalid         = m_valid_reg;
    assign key_out          = key_out_reg;
    assign value_out        = value_out_reg;
    assign dim_index        = dim_out_reg;
    assign position_index   = pos_out_reg;
    assign filled_positions = filled_out_reg;
    assign last             = last_out_reg;

`ifndef ASSERT_OFF
    a_issue_has_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.issue |-> (!rd_valid_reg || out_free))
        else $error("read issued while the read stage is blocked");

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_count_reg <= FILL_W'(WINDOW_DEPTH))
        else $error("fill count above ring depth");

    a_no_write_during_read: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.append && cmd.issue))
        else $error("store written while the window is being read");
`endif

endmodule

[rtl/sliding_window_kv_store_core.sv]
// top level of the sliding window key/value store
//
// Keeps the key and value vectors of the most recent WINDOW_DEPTH positions in a
// ring held in two simple dual port memories of WINDOW_DEPTH*DIM_MAX words. Each
// accepted input word carries one key and one value element and is stored; vec_len
// words make a position. A word with tlast set stores its element, drops any
// unfinished position, and then streams out the newest min(filled, win_len)
// positions, oldest first, all positions of dimension 0, then dimension 1 and so
// on, one word per cycle while m_tready is high. If the window holds a position,
// the first read is issued in the cycle after the tlast word is taken; each word
// then passes the memory's registered read and the output register before it
// shows on m_tvalid, and the window read is paced by the single read port.
// No input word is taken from the tlast word until every read is issued and the
// read stage has handed its word to the output register; a finished word may still
// wait there while the next input word is taken. A word with tuser set empties the
// ring and gives no result. Registers are written through cfg_we/cfg_addr/cfg_wdata
// (0: win_len, 1: vec_len, both 4 bits, out of range values clamp to 1..8) and
// should only change while the block is idle. The memories need no clearing after
// reset: only written slots are read back unless vec_len grows on a filled ring.
module sliding_window_kv_store_core (
    input  logic                               aclk,
    input  logic                               aresetn,
    // configuration write port
    input  logic                               cfg_we,
    input  logic [swkv_pkg::CFG_IDX_W-1:0]     cfg_addr,
    input  logic [swkv_pkg::CFG_W-1:0]         cfg_wdata,
    // input words
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [swkv_pkg::S_TDATA_W-1:0]     s_tdata,   // key_bits, value_bits
    input  logic                               s_tlast,   // end_of_update
    input  logic                               s_tuser,   // clear_cache
    // result words
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // key_out, value_out, dim_index, position_index, filled_positions, zero fill
    output logic [swkv_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic                               m_tlast    // last
);

    import swkv_pkg::*;

    cmd_t    cmd;
    status_t status;

    logic [WORD_W-1:0]   key_in;
    logic [WORD_W-1:0]   value_in;
    logic [WORD_W-1:0]   key_out;
    logic [WORD_W-1:0]   value_out;
    logic [IDX_W-1:0]    dim_index;
    logic [IDX_W-1:0]    position_index;
    logic [FILLED_W-1:0] filled_positions;

    // unpack the input word, key in the low half
    assign key_in   = s_tdata[WORD_W-1:0];
    assign value_in = s_tdata[2*WORD_W-1:WORD_W];

    // sequencing: accept, clear, and window read issue
    swkv_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tlast  (s_tlast),
        .s_tuser  (s_tuser),
        .status   (status),
        .cmd      (cmd)
    );

    // ring pointers, memories, read stage and output register
    swkv_dp u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_addr         (cfg_addr),
        .cfg_wdata        (cfg_wdata),
        .cmd              (cmd),
        .status           (status),
        .key_in           (key_in),
        .value_in         (value_in),
        .end_in           (s_tlast),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .key_out          (key_out),
        .value_out        (value_out),
        .dim_index        (dim_index),
        .position_index   (position_index),
        .filled_positions (filled_positions),
        .last             (m_tlast)
    );

    // pack the result word, first field lowest, zero fill to whole bytes
    assign m_tdata = {{M_PAD_W{1'b0}}, filled_positions, position_index, dim_index,
                      value_out, key_out};

endmodule

[verif/tb.sv]
`timescale 1ns / 100ps
// self-checking testbench for the sliding window key/value store
module tb;
    import swkv_pkg::*;

    localparam int CLK_PERIOD     = 10;
    localparam int TIMEOUT_CYCLES = 1_000_000;
    localparam int SETTLE_CYCLES  = 8;     // lets a word that gives no result pass through
    localparam int HOLD_CYCLES    = 300;   // long sink hold-off, fills the block
    localparam int PHASE_WORDS    = 44;

    // result word field positions inside m_tdata
    localparam int DIM_LSB  = 2 * WORD_W;
    localparam int POS_LSB  = DIM_LSB + IDX_W;
    localparam int FILL_LSB = POS_LSB + IDX_W;

    typedef struct packed {
        logic [WORD_W-1:0]   key;
        logic [WORD_W-1:0]   value;
        logic [IDX_W-1:0]    dim;
        logic [IDX_W-1:0]    pos;
        logic [FILLED_W-1:0] filled;
        logic                last;
    } window_word_t;

    // tracks the ring contents and holds the window words still to come out
    class kv_window_scoreboard;
        logic [WORD_W-1:0] key_mem   [STORE_DEPTH];
        logic [WORD_W-1:0] value_mem [STORE_DEPTH];
        int unsigned       wr_slot;
        int unsigned       fill;
        int unsigned       dim_cnt;
        logic [CFG_W-1:0]  window_reg;
        logic [CFG_W-1:0]  vec_len_reg;
        window_word_t      window_q[$];
        int unsigned       errors;
        int unsigned       words_in;
        int unsigned       words_out;
        int unsigned       clears;
        int unsigned       drops;

        function new();
            wr_slot     = 0;
            fill        = 0;
            dim_cnt     = 0;
            window_reg  = WIN_LEN_RST;
            vec_len_reg = VEC_LEN_RST;
            errors      = 0;
            words_in    = 0;
            words_out   = 0;
            clears      = 0;
            drops       = 0;
        endfunction

        // out of range settings act as the nearest legal one
        function int unsigned clamp_cfg(logic [CFG_W-1:0] v, int unsigned hi);
            if (v == 0) return 1;
            if (v > hi) return hi;
            return v;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] v);
            case (idx)
                CFG_WIN_LEN: window_reg = v;
                CFG_VEC_LEN: vec_len_reg = v;
                default: ;
            endcase
        endfunction

        // store one element and, on an end mark, queue the emitted window
        function void note_input_word(logic [WORD_W-1:0] k, logic [WORD_W-1:0] v,
                                      logic end_mark, logic clr);
            int unsigned  hd;
            int unsigned  ws;
            int unsigned  n;
            int unsigned  slot;
            int unsigned  addr;
            window_word_t w;
            hd = clamp_cfg(vec_len_reg, DIM_MAX);
            ws = clamp_cfg(window_reg, WINDOW_DEPTH);
            words_in++;
            if (clr) begin
                clears++;
                wr_slot = 0;
                fill    = 0;
                dim_cnt = 0;
                return;
            end
            addr = wr_slot * DIM_MAX + dim_cnt;
            key_mem[addr]   = k;
            value_mem[addr] = v;
            if (dim_cnt + 1 >= hd) begin
                dim_cnt = 0;
                wr_slot = (wr_slot + 1) % WINDOW_DEPTH;
                if (fill < WINDOW_DEPTH) fill++;
            end else begin
                dim_cnt++;
            end
            if (!end_mark) return;
            if (dim_cnt != 0) drops++;
            dim_cnt = 0;
            n = (fill < ws) ? fill : ws;
            // dimension-major: every position of dim 0 first, oldest position first
            for (int unsigned d = 0; d < hd; d++) begin
                for (int unsigned t = 0; t < n; t++) begin
                    slot     = (wr_slot + WINDOW_DEPTH - n + t) % WINDOW_DEPTH;
                    addr     = slot * DIM_MAX + d;
                    w.key    = key_mem[addr];
                    w.value  = value_mem[addr];
                    w.dim    = d[IDX_W-1:0];
                    w.pos    = t[IDX_W-1:0];
                    w.filled = fill[FILLED_W-1:0];
                    w.last   = (d + 1 == hd) && (t + 1 == n);
                    window_q.push_back(w);
                end
            end
        endfunction

        task report_mismatch(string msg);
            errors++;
            $display("mismatch: %s", msg);
        endtask

        task check_field(string name, logic [WORD_W-1:0] got, logic [WORD_W-1:0] want);
            if (got !== want)
                report_mismatch($sformatf("result word %0d, %s is %h, expected %h",
                                          words_out, name, got, want));
        endtask

        task check_result_word(window_word_t got);
            window_word_t want;
            words_out++;
            if (window_q.size() == 0) begin
                report_mismatch($sformatf("result word %0d with none expected, key %h",
                                          words_out, got.key));
                return;
            end
            want = window_q.pop_front();
            check_field("key_out", got.key, want.key);
            check_field("value_out", got.value, want.value);
            check_field("dim_index", got.dim, want.dim);
            check_field("position_index", got.pos, want.pos);
            check_field("filled_positions", got.filled, want.filled);
            check_field("last", got.last, want.last);
        endtask
    endclass

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_addr  = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;   // key_bits, value_bits
    logic                 s_tlast   = 1'b0; // end_of_update
    logic                 s_tuser   = 1'b0; // clear_cache
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;          // key, value, dim, position, filled, zero fill
    logic                 m_tlast;          // last

    kv_window_scoreboard sb = new;

    int unsigned src_idle_pct  = 18;
    int unsigned sink_idle_pct = 73;
    int          hold_left     = 0;
    int unsigned words_sent    = 0;
    int unsigned n_settings    = 0;

    sliding_window_kv_store_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always begin
        #(CLK_PERIOD / 2) aclk = 1'b1;
        #(CLK_PERIOD / 2) aclk = 1'b0;
    end

    // sink: random back-pressure, or a counted hold-off when one is requested
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            m_tready  = 1'b0;
            hold_left = hold_left - 1;
        end else begin
            m_tready = ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // everything is sampled on the rising edge, before the block updates
    always @(posedge aclk) begin : watch_ports
        window_word_t got;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got.key    = m_tdata[WORD_W-1:0];
                got.value  = m_tdata[2*WORD_W-1:WORD_W];
                got.dim    = m_tdata[DIM_LSB +: IDX_W];
                got.pos    = m_tdata[POS_LSB +: IDX_W];
                got.filled = m_tdata[FILL_LSB +: FILLED_W];
                got.last   = m_tlast;
                sb.check_result_word(got);
            end
            if (cfg_we) sb.write_reg(cfg_addr, cfg_wdata);
            if (s_tvalid && s_tready)
                sb.note_input_word(s_tdata[WORD_W-1:0], s_tdata[2*WORD_W-1:WORD_W],
                                   s_tlast, s_tuser);
        end
    end

    // offer one word; returns at the falling edge after it is taken, tvalid still high
    task automatic send_word(logic [WORD_W-1:0] k, logic [WORD_W-1:0] v,
                             logic end_mark, logic clr);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {v, k};
        s_tlast  = end_mark;
        s_tuser  = clr;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
        words_sent++;
    endtask

    // stop offering and let every expected word drain out
    task automatic wait_idle();
        s_tvalid = 1'b0;
        while (sb.window_q.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] v);
        cfg_we    = 1'b1;
        cfg_addr  = idx;
        cfg_wdata = v;
        @(negedge aclk);
        cfg_we    = 1'b0;
    endtask

    task automatic apply_settings(logic [CFG_W-1:0] ws, logic [CFG_W-1:0] hd);
        int unsigned old_hd;
        wait_idle();
        old_hd = sb.clamp_cfg(sb.vec_len_reg, DIM_MAX);
        write_cfg(CFG_WIN_LEN, ws);
        write_cfg(CFG_VEC_LEN, hd);
        n_settings++;
        // a longer vector would read dims the stored positions never had, so empty the ring
        if (sb.clamp_cfg(hd, DIM_MAX) > old_hd)
            send_word($urandom, $urandom, 1'($urandom_range(1)), 1'b1);
    endtask

    // mostly whole positions ending in an end mark, now and then a clear or a torn tail
    task automatic send_update(int unsigned hd);
        int unsigned n_pos;
        int unsigned n_tail;
        int unsigned n_words;
        if ($urandom_range(19) == 0)
            send_word($urandom, $urandom, 1'($urandom_range(1)), 1'b1);
        if (hd <= 2 && $urandom_range(3) == 0)
            n_pos = $urandom_range(10, 4);    // wraps the ring
        else
            n_pos = $urandom_range(3, 1);
        n_tail = (hd > 1 && $urandom_range(7) == 0) ? $urandom_range(hd - 1, 1) : 0;
        if (n_tail != 0 && $urandom_range(3) == 0) n_pos = 0;
        n_words = n_pos * hd + n_tail;
        for (int unsigned i = 0; i < n_words; i++)
            send_word($urandom, $urandom, (i == n_words - 1), 1'b0);
    endtask

    initial begin : stimulus
        logic [CFG_W-1:0] ws_list [6];
        logic [CFG_W-1:0] hd_list [6];
        int unsigned      first_word;
        ws_list = '{4'd15, 4'd1, 4'd8, 4'd0, 4'd6, 4'd3};
        hd_list = '{4'd3, 4'd8, 4'd15, 4'd4, 4'd1, 4'd5};

        repeat (9) @(negedge aclk);
        aresetn = 1'b1;

        // directed part, small window and vector length so that positions stay short
        apply_settings(4'd2, 4'd2);
        // end mark on an empty ring: element stored, then dropped, nothing emitted
        send_word(32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 1'b0);
        send_word(32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 1'b0);
        send_word(32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 1'b0);
        // end mark in the middle of a position
        send_word(32'hA5A5_A5A5, 32'h5A5A_5A5A, 1'b1, 1'b0);
        // clear with the end mark set as well, the mark has no effect
        send_word($urandom, $urandom, 1'b1, 1'b1);
        // three positions, only the newest two come out
        for (int i = 0; i < 6; i++) send_word($urandom, $urandom, (i == 5), 1'b0);
        // leave a position open, then drop the vector length to the open count
        // (0 acts as 1)
        send_word(32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b0);
        apply_settings(4'd2, 4'd0);
        send_word(32'h1234_5678, 32'h9ABC_DEF0, 1'b1, 1'b0);

        // random part: two settings per idling profile
        for (int p = 0; p < 6; p++) begin
            if (p == 2) begin
                src_idle_pct  = 73;
                sink_idle_pct = 18;
            end else if (p == 4) begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
            end
            apply_settings(ws_list[p], hd_list[p]);
            // hold the sink off for a while so the block backs up into the input
            if (p == 1) hold_left = HOLD_CYCLES;
            first_word = words_sent;
            while (words_sent - first_word < PHASE_WORDS)
                send_update(sb.clamp_cfg(sb.vec_len_reg, DIM_MAX));
        end

        wait_idle();
        $display("covered %0d input words (%0d clears, %0d torn positions), %0d result words",
                 sb.words_in, sb.clears, sb.drops, sb.words_out);
        $display("across %0d register settings, three idling profiles and one long sink stall",
                 n_settings);
        if (sb.errors == 0 && sb.window_q.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin : watchdog
        #(CLK_PERIOD * TIMEOUT_CYCLES);
        $display("timeout with %0d result words still expected", sb.window_q.size());
        $display("DONE: errors detected");
        $finish;
    end

endmodule
